// ----- hw/rtl/utfsan_pkg.sv -----
// Shared types, constants and decode helpers for the UTF-8 sanitiser.
package utfsan_pkg;

    localparam logic [7:0] REPL_B0 = 8'hEF;
    localparam logic [7:0] REPL_B1 = 8'hBF;
    localparam logic [7:0] REPL_B2 = 8'hBD;
    localparam int unsigned SEQ_MAX = 4;

    typedef enum logic [1:0] {
        CMD_SEQ  = 2'd0,
        CMD_REPL = 2'd1,
        CMD_END  = 2'd2
    } cmd_kind_t;

    typedef logic [7:0] byte_t;

    typedef struct packed {
        cmd_kind_t                  kind;
        logic [1:0]                 len_m1;
        logic [SEQ_MAX-1:0][7:0]    bytes;
    } cmd_t;

    // Sequence length implied by a lead byte, zero if it cannot lead.
    function automatic logic [2:0] lead_len(input byte_t b);
        logic [2:0] len;
        if (b < 8'h80)
            len = 3'd1;
        else if (b < 8'hC2)
            len = 3'd0;
        else if (b < 8'hE0)
            len = 3'd2;
        else if (b < 8'hF0)
            len = 3'd3;
        else if (b < 8'hF5)
            len = 3'd4;
        else
            len = 3'd0;
        return len;
    endfunction

    function automatic logic is_cont(input byte_t b);
        return (b >= 8'h80) && (b <= 8'hBF);
    endfunction

    // All len bytes present, s0 is a valid lead.
    function automatic logic seq_legal(input byte_t s0, input byte_t s1,
                                       input byte_t s2, input byte_t s3,
                                       input logic [2:0] len);
        byte_t lo;
        byte_t hi;
        logic  ok;
        lo = 8'h80;
        hi = 8'hBF;
        ok = 1'b1;
        if (s0 == 8'hE0)
            lo = 8'hA0;
        else if (s0 == 8'hED)
            hi = 8'h9F;
        else if (s0 == 8'hF0)
            lo = 8'h90;
        else if (s0 == 8'hF4)
            hi = 8'h8F;
        if (len >= 3'd2 && (s1 < lo || s1 > hi))
            ok = 1'b0;
        if (len >= 3'd3 && !is_cont(s2))
            ok = 1'b0;
        if (len >= 3'd4 && !is_cont(s3))
            ok = 1'b0;
        return ok;
    endfunction

endpackage

// ----- hw/rtl/utf8_sanitize_with_replacement_unit.sv -----
// UTF-8 sanitiser top level: byte in, validated or replaced bytes out.
//
// Input side is a queue write port: a byte with its last mark is taken on a
// clock edge with push high and full low. Output side is a queue read port:
// while empty is low the oldest byte sits on out_byte/out_last and pop takes it.
// Well-formed UTF-8 passes unchanged; each ill-formed position gives EF BF BD
// (runs merge into one), and every string closes with a 0 byte marked last.
// The front end scans a window of up to four bytes, one scan step per cycle
// while the queue has space, and posts commands into a QUEUE_DEPTH-entry
// queue; the back end turns each command into output bytes, one per cycle
// while pop is high. An accepted byte keeps full high while it is scanned:
// a step for each command it yields, or a step that only holds it, and a
// further step for the closing 0 at end of string. The first resulting byte
// passes the command queue and the back end's command register to the outputs.
// A stalled receiver fills the command queue; the front end then holds full
// high until space frees. Reset empties the queue, drops held bytes and
// clears the merge flag; it takes effect at once.
module utf8_sanitize_with_replacement_unit
    import utfsan_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic [7:0]  in_byte,
    input  logic        in_last,
    output logic        full,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  out_byte,
    output logic        out_last
);

    cmd_t q_wr_data;
    cmd_t q_rd_data;
    logic q_wr;
    logic q_full;
    logic q_rd;
    logic q_not_empty;

    utfsan_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .in_byte  (in_byte),
        .in_last  (in_last),
        .full     (full),
        .cmd_push (q_wr),
        .cmd      (q_wr_data),
        .cmd_full (q_full)
    );

    utfsan_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (q_wr),
        .wr_data   (q_wr_data),
        .full      (q_full),
        .rd_en     (q_rd),
        .rd_data   (q_rd_data),
        .not_empty (q_not_empty)
    );

    utfsan_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_not_empty),
        .cmd       (q_rd_data),
        .cmd_pop   (q_rd),
        .empty     (empty),
        .pop       (pop),
        .out_byte  (out_byte),
        .out_last  (out_last)
    );

endmodule

// ----- hw/rtl/utfsan_front.sv -----
// Front end: collects bytes, scans the held window and issues commands.
module utfsan_front
    import utfsan_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  byte_t  in_byte,
    input  logic   in_last,
    output logic   full,
    output logic   cmd_push,
    output cmd_t   cmd,
    input  logic   cmd_full
);

    byte_t      buf_reg  [SEQ_MAX];
    byte_t      buf_next [SEQ_MAX];
    logic [2:0] cnt_reg, cnt_next;
    logic       last_reg, last_next;
    logic       busy_reg, busy_next;

    logic [2:0] len;
    logic [2:0] sh;
    logic [2:0] j;
    logic       legal;

    assign full  = busy_reg;
    assign len   = lead_len(buf_reg[0]);
    assign legal = seq_legal(buf_reg[0], buf_reg[1], buf_reg[2], buf_reg[3], len);

    always_comb
    begin
        buf_next  = buf_reg;
        cnt_next  = cnt_reg;
        last_next = last_reg;
        busy_next = busy_reg;
        cmd_push  = 1'b0;
        sh        = 3'd0;
        j         = 3'd0;
        cmd.kind  = CMD_REPL;
        cmd.len_m1 = 2'(len - 3'd1);
        for (int i = 0; i < SEQ_MAX; i++)
        begin
            cmd.bytes[i] = buf_reg[i];
        end

        if (!busy_reg)
        begin
            if (push)
            begin
                // idle implies at most three bytes held
                buf_next[cnt_reg[1:0]] = in_byte;
                cnt_next  = cnt_reg + 3'd1;
                last_next = in_last;
                busy_next = 1'b1;
            end
        end
        else if (!cmd_full)
        begin
            if (cnt_reg == 3'd0)
            begin
                if (last_reg)
                begin
                    cmd_push = 1'b1;
                    cmd.kind = CMD_END;
                end
                busy_next = 1'b0;
                last_next = 1'b0;
            end
            else if (len == 3'd0)
            begin
                cmd_push = 1'b1;
                sh       = 3'd1;
            end
            else if (len > cnt_reg)
            begin
                // incomplete sequence: hold it, or replace it at end of string
                if (last_reg)
                begin
                    cmd_push = 1'b1;
                    cnt_next = 3'd0;
                end
                else
                begin
                    busy_next = 1'b0;
                end
            end
            else if (legal)
            begin
                cmd_push = 1'b1;
                cmd.kind = CMD_SEQ;
                sh       = len;
            end
            else
            begin
                cmd_push = 1'b1;
                sh       = 3'd1;
            end

            if (sh != 3'd0)
            begin
                for (int i = 0; i < SEQ_MAX; i++)
                begin
                    j = 3'(i) + sh;
                    if (j < 3'(SEQ_MAX))
                        buf_next[i] = buf_reg[j[1:0]];
                end
                cnt_next = cnt_reg - sh;
                if (cnt_next == 3'd0 && !last_reg)
                    busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 3'd0;
            last_reg <= 1'b0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            last_reg <= last_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

endmodule

// ----- hw/rtl/utfsan_fifo.sv -----
// Small command queue between front and back end.
module utfsan_fifo
    import utfsan_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   wr_en,
    input  cmd_t   wr_data,
    output logic   full,
    input  logic   rd_en,
    output cmd_t   rd_data,
    output logic   not_empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_wr, do_rd;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign rd_data   = mem[rd_ptr_reg];
    assign do_wr     = wr_en && !full;
    assign do_rd     = rd_en && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_data;
    end

endmodule

// ----- hw/rtl/utfsan_back.sv -----
// Back end: expands commands into output bytes, merges adjacent replacements.
module utfsan_back
    import utfsan_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   cmd_valid,
    input  cmd_t   cmd,
    output logic   cmd_pop,
    output logic   empty,
    input  logic   pop,
    output byte_t  out_byte,
    output logic   out_last
);

    cmd_t       cur_reg, cur_next;
    logic       valid_reg, valid_next;
    logic [1:0] idx_reg, idx_next;
    logic       repl_sent_reg, repl_sent_next;
    logic [1:0] end_idx;
    logic       at_end;
    logic       slot_free;

    assign empty = !valid_reg;

    always_comb
    begin
        case (cur_reg.kind)
            CMD_SEQ:  end_idx = cur_reg.len_m1;
            CMD_REPL: end_idx = 2'd2;
            default:  end_idx = 2'd0;
        endcase
    end

    assign at_end    = (idx_reg == end_idx);
    assign slot_free = !valid_reg || (pop && at_end);
    assign cmd_pop   = cmd_valid && slot_free;

    always_comb
    begin
        out_last = 1'b0;
        case (cur_reg.kind)
            CMD_SEQ:
                out_byte = cur_reg.bytes[idx_reg];
            CMD_REPL:
            begin
                case (idx_reg)
                    2'd0:    out_byte = REPL_B0;
                    2'd1:    out_byte = REPL_B1;
                    default: out_byte = REPL_B2;
                endcase
            end
            default:
            begin
                out_byte = 8'h00;
                out_last = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        cur_next       = cur_reg;
        valid_next     = valid_reg;
        idx_next       = idx_reg;
        repl_sent_next = repl_sent_reg;
        if (valid_reg && pop)
        begin
            idx_next = idx_reg + 2'd1;
            if (at_end)
                valid_next = 1'b0;
        end
        if (cmd_pop)
        begin
            // a replacement right after another one is dropped here
            if (cmd.kind == CMD_REPL && repl_sent_reg)
            begin
                valid_next = 1'b0;
            end
            else
            begin
                cur_next       = cmd;
                valid_next     = 1'b1;
                idx_next       = 2'd0;
                repl_sent_next = (cmd.kind == CMD_REPL);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            idx_reg       <= 2'd0;
            repl_sent_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            idx_reg       <= idx_next;
            repl_sent_reg <= repl_sent_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

endmodule

// ----- hw/rtl/utfsan_checker.sv -----
// Port-level checks for the UTF-8 sanitiser, bound to the top level.
module utfsan_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic [7:0]  in_byte,
    input  logic        in_last,
    input  logic        full,
    input  logic        empty,
    input  logic        pop,
    input  logic [7:0]  out_byte,
    input  logic        out_last
);

    // reset leaves both sides idle once a reset edge has gone by
    a_reset_idle: assert property (@(posedge clk)
        (!rst_n ##1 !rst_n) |-> (!full && empty))
        else $error("ports not idle during reset");

    // the closing byte of a string is always zero
    a_last_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_last) |-> (out_byte == 8'h00))
        else $error("closing byte not zero");

    // every accepted byte raises full for a scan step
    a_scan_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full) |=> full)
        else $error("front end took a byte without scanning");

    // a waiting result holds while the receiver stalls
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(out_last)))
        else $error("result changed while stalled");

endmodule

bind utf8_sanitize_with_replacement_unit utfsan_checker u_checker (.*);

// ----- bench/tb_utf8_sanitize_with_replacement_unit.sv -----
// Self-checking testbench for the UTF-8 sanitiser with replacement character.
module tb_utf8_sanitize_with_replacement_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import utfsan_pkg::*;

    localparam int IDLE_PCT     = 27;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int MAX_PRINTED  = 40;
    localparam int MIXED_BYTES  = 60;
    localparam int STREAM_BYTES = 40;
    localparam int HOLD_BYTES   = 30;

    typedef struct packed {
        byte_t data;
        logic  last;
    } out_item_t;

    typedef enum int {
        CH_ASCII,
        CH_TWO,
        CH_THREE,
        CH_FOUR
    } char_kind_t;

    typedef enum int {
        NZ_RANDOM,
        NZ_TRUNCATED,
        NZ_OVERLONG,
        NZ_SURROGATE,
        NZ_TOO_HIGH,
        NZ_BAD_CONT
    } noise_kind_t;

    logic       clk;
    logic       rst_n;
    logic       push;
    logic [7:0] in_byte;
    logic       in_last;
    logic       full;
    logic       empty;
    logic       pop;
    logic [7:0] out_byte;
    logic       out_last;

    // expected output stream and the sanitiser state mirrored here
    out_item_t  expected_bytes[$];
    out_item_t  head_item;
    byte_t      held_seq[3];
    int         held_cnt;
    bit         repl_just_sent;

    byte_t      str_buf[$];
    int         errors;
    int         bytes_sent;
    int         strings_sent;
    int         results_checked;
    int         repl_runs;
    int         cycle_count;
    int         hold_request;
    bit         no_idle;

    utf8_sanitize_with_replacement_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .in_byte  (in_byte),
        .in_last  (in_last),
        .full     (full),
        .empty    (empty),
        .pop      (pop),
        .out_byte (out_byte),
        .out_last (out_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        errors++;
        if (errors <= MAX_PRINTED)
            $display("mismatch at %0t: %s", $time, what);
    endtask

    // ---------------------------------------------------------------
    // Expected-stream model
    // ---------------------------------------------------------------
    function automatic int utf8_len_from_lead(input byte_t b);
        if (b[7] == 1'b0)
            return 1;
        if (b >= 8'hC2 && b <= 8'hDF)
            return 2;
        if (b >= 8'hE0 && b <= 8'hEF)
            return 3;
        if (b >= 8'hF0 && b <= 8'hF4)
            return 4;
        return 0;
    endfunction

    // seq holds the lead in its top byte; len is 2..4
    function automatic bit wellformed(input logic [31:0] seq, input int len);
        byte_t lo;
        byte_t hi;
        byte_t second;
        bit    ok;
        lo = 8'h80;
        hi = 8'hBF;
        second = seq[23:16];
        case (seq[31:24])
            8'hE0: lo = 8'hA0;
            8'hED: hi = 8'h9F;
            8'hF0: lo = 8'h90;
            8'hF4: hi = 8'h8F;
            default: ;
        endcase
        ok = (second >= lo) && (second <= hi);
        if (len >= 3 && seq[15:14] != 2'b10)
            ok = 1'b0;
        if (len == 4 && seq[7:6] != 2'b10)
            ok = 1'b0;
        return ok;
    endfunction

    task automatic expect_byte(input byte_t b, input logic last);
        expected_bytes.push_back('{data: b, last: last});
    endtask

    task automatic expect_replacement();
        if (!repl_just_sent)
        begin
            repl_just_sent = 1'b1;
            repl_runs++;
            expect_byte(REPL_B0, 1'b0);
            expect_byte(REPL_B1, 1'b0);
            expect_byte(REPL_B2, 1'b0);
        end
    endtask

    task automatic sanitise_byte(input byte_t b, input logic last);
        byte_t       win[4];
        logic [31:0] seq;
        int          n;
        int          p;
        int          len;
        int          i;
        bit          stalled;
        n = 0;
        p = 0;
        stalled = 1'b0;
        for (i = 0; i < held_cnt; i++)
        begin
            win[n] = held_seq[i];
            n++;
        end
        win[n] = b;
        n++;
        while (p < n && !stalled)
        begin
            len = utf8_len_from_lead(win[p]);
            if (len == 0)
            begin
                expect_replacement();
                p++;
            end
            else if (p + len > n)
            begin
                stalled = 1'b1;
            end
            else
            begin
                seq = '0;
                for (i = 0; i < len; i++)
                    seq[31 - 8*i -: 8] = win[p + i];
                if (len == 1 || wellformed(seq, len))
                begin
                    repl_just_sent = 1'b0;
                    for (i = 0; i < len; i++)
                        expect_byte(win[p + i], 1'b0);
                    p += len;
                end
                else
                begin
                    // drop the lead only, rescan the rest
                    expect_replacement();
                    p++;
                end
            end
        end
        if (last)
        begin
            if (p < n)
                expect_replacement();
            expect_byte(8'h00, 1'b1);
            held_cnt = 0;
            repl_just_sent = 1'b0;
            strings_sent++;
        end
        else
        begin
            held_cnt = n - p;
            for (i = 0; i < held_cnt; i++)
                held_seq[i] = win[p + i];
        end
    endtask

    // ---------------------------------------------------------------
    // Sender
    // ---------------------------------------------------------------
    task automatic send_byte(input byte_t b, input logic last);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push    <= 1'b1;
        in_byte <= b;
        in_last <= last;
        do
            @(posedge clk);
        while (full !== 1'b0);
        sanitise_byte(b, last);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_buffered_string();
        int i;
        for (i = 0; i < str_buf.size(); i++)
            send_byte(str_buf[i], i == str_buf.size() - 1);
        str_buf.delete();
    endtask

    function automatic byte_t cont_byte();
        return byte_t'($urandom_range(8'h80, 8'hBF));
    endfunction

    task automatic add_valid_char();
        char_kind_t kind;
        byte_t      lead;
        kind = char_kind_t'($urandom_range(0, 3));
        case (kind)
            CH_ASCII:
                str_buf.push_back(byte_t'($urandom_range(8'h00, 8'h7F)));
            CH_TWO:
            begin
                str_buf.push_back(byte_t'($urandom_range(8'hC2, 8'hDF)));
                str_buf.push_back(cont_byte());
            end
            CH_THREE:
            begin
                lead = byte_t'($urandom_range(8'hE0, 8'hEF));
                str_buf.push_back(lead);
                if (lead == 8'hE0)
                    str_buf.push_back(byte_t'($urandom_range(8'hA0, 8'hBF)));
                else if (lead == 8'hED)
                    str_buf.push_back(byte_t'($urandom_range(8'h80, 8'h9F)));
                else
                    str_buf.push_back(cont_byte());
                str_buf.push_back(cont_byte());
            end
            default:
            begin
                lead = byte_t'($urandom_range(8'hF0, 8'hF4));
                str_buf.push_back(lead);
                if (lead == 8'hF0)
                    str_buf.push_back(byte_t'($urandom_range(8'h90, 8'hBF)));
                else if (lead == 8'hF4)
                    str_buf.push_back(byte_t'($urandom_range(8'h80, 8'h8F)));
                else
                    str_buf.push_back(cont_byte());
                str_buf.push_back(cont_byte());
                str_buf.push_back(cont_byte());
            end
        endcase
    endtask

    task automatic add_noise();
        noise_kind_t kind;
        kind = noise_kind_t'($urandom_range(0, 5));
        case (kind)
            NZ_RANDOM:
                str_buf.push_back(byte_t'($urandom_range(0, 255)));
            NZ_TRUNCATED:
            begin
                str_buf.push_back(byte_t'($urandom_range(8'hE1, 8'hEC)));
                str_buf.push_back(cont_byte());
            end
            NZ_OVERLONG:
            begin
                case ($urandom_range(0, 2))
                    0: str_buf.push_back(byte_t'($urandom_range(8'hC0, 8'hC1)));
                    1:
                    begin
                        str_buf.push_back(8'hE0);
                        str_buf.push_back(byte_t'($urandom_range(8'h80, 8'h9F)));
                    end
                    default:
                    begin
                        str_buf.push_back(8'hF0);
                        str_buf.push_back(byte_t'($urandom_range(8'h80, 8'h8F)));
                        str_buf.push_back(cont_byte());
                    end
                endcase
                str_buf.push_back(cont_byte());
            end
            NZ_SURROGATE:
            begin
                str_buf.push_back(8'hED);
                str_buf.push_back(byte_t'($urandom_range(8'hA0, 8'hBF)));
                str_buf.push_back(cont_byte());
            end
            NZ_TOO_HIGH:
            begin
                if ($urandom_range(0, 1))
                begin
                    str_buf.push_back(8'hF4);
                    str_buf.push_back(byte_t'($urandom_range(8'h90, 8'hBF)));
                    str_buf.push_back(cont_byte());
                    str_buf.push_back(cont_byte());
                end
                else
                    str_buf.push_back(byte_t'($urandom_range(8'hF5, 8'hFF)));
            end
            default:
            begin
                str_buf.push_back(byte_t'($urandom_range(8'hC2, 8'hDF)));
                if ($urandom_range(0, 1))
                    str_buf.push_back(byte_t'($urandom_range(8'h00, 8'h7F)));
                else
                    str_buf.push_back(byte_t'($urandom_range(8'hC0, 8'hFF)));
            end
        endcase
    endtask

    // mostly well-formed characters, with ill-formed ones mixed in per noise_pct
    task automatic send_random_strings(input int byte_budget, input int noise_pct);
        int start;
        int nchars;
        int c;
        start = bytes_sent;
        while (bytes_sent - start < byte_budget)
        begin
            nchars = $urandom_range(1, 8);
            for (c = 0; c < nchars; c++)
            begin
                if ($urandom_range(0, 99) < noise_pct)
                    add_noise();
                else
                    add_valid_char();
            end
            send_buffered_string();
        end
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    task automatic test_empty_content();
        str_buf = '{8'h00};
        send_buffered_string();
        str_buf = '{8'h7F};
        send_buffered_string();
    endtask

    task automatic test_valid_sequences();
        str_buf = '{8'hC2, 8'h80, 8'hE0, 8'hA0, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
        send_buffered_string();
    endtask

    task automatic test_bad_leads();
        str_buf = '{8'h80, 8'hC1, 8'hF5, 8'hFF};
        send_buffered_string();
    endtask

    // bad continuation, surrogate, above U+10FFFF; lead dropped and rest rescanned
    task automatic test_bad_sequences();
        str_buf = '{8'hC2, 8'h41, 8'hED, 8'hA0, 8'h80, 8'hF4, 8'h90, 8'h80, 8'h80};
        send_buffered_string();
    endtask

    // held bytes dropped at end of string, non-continuation included
    task automatic test_cut_short();
        str_buf = '{8'hE2, 8'h41};
        send_buffered_string();
    endtask

    task automatic test_random_mixed();
        send_random_strings(MIXED_BYTES, 20);
    endtask

    task automatic test_back_to_back();
        no_idle = 1'b1;
        send_random_strings(STREAM_BYTES, 10);
        no_idle = 1'b0;
    endtask

    task automatic test_receiver_hold_off();
        hold_request = HOLD_CYCLES;
        send_random_strings(HOLD_BYTES, 0);
    endtask

    // ---------------------------------------------------------------
    // Receiver and result checking
    // ---------------------------------------------------------------
    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request != 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                pop <= 1'b0;
                hold_left--;
            end
            else
                pop <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && pop === 1'b1 && empty === 1'b0)
        begin
            results_checked++;
            if (expected_bytes.size() == 0)
                report_mismatch($sformatf("unexpected byte %02h last %0b",
                                          out_byte, out_last));
            else
            begin
                head_item = expected_bytes.pop_front();
                if (out_byte !== head_item.data)
                    report_mismatch($sformatf("out_byte %02h, wanted %02h",
                                              out_byte, head_item.data));
                if (out_last !== head_item.last)
                    report_mismatch($sformatf("out_last %0b, wanted %0b on byte %02h",
                                              out_last, head_item.last, head_item.data));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout with %0d bytes outstanding", expected_bytes.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Sequencing
    // ---------------------------------------------------------------
    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        in_byte = 8'h00;
        in_last = 1'b0;
        no_idle = 1'b0;
        hold_request = 0;
        held_cnt = 0;
        repl_just_sent = 1'b0;
        errors = 0;
        bytes_sent = 0;
        strings_sent = 0;
        results_checked = 0;
        repl_runs = 0;
        cycle_count = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_empty_content();
        test_valid_sequences();
        test_bad_leads();
        test_bad_sequences();
        test_cut_short();
        test_random_mixed();
        test_back_to_back();
        test_receiver_hold_off();

        push <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        $display("run: %0d input bytes in %0d strings, %0d output bytes compared, %0d replacements",
                 bytes_sent, strings_sent, results_checked, repl_runs);
        $display("run: edge cases, noisy random strings, gap-free streaming, %0d-cycle pop hold-off",
                 HOLD_CYCLES);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/utfsan_pkg.sv
hw/rtl/utfsan_front.sv
hw/rtl/utfsan_fifo.sv
hw/rtl/utfsan_back.sv
hw/rtl/utf8_sanitize_with_replacement_unit.sv
hw/rtl/utfsan_checker.sv
bench/tb_utf8_sanitize_with_replacement_unit.sv
